>>> rtl/core/gifp_pkg.sv
// Shared types and constants for the GIF container block parser.
`timescale 1ns / 1ps
package gifp_pkg;

    typedef enum logic [4:0] {
        ST_SIG, ST_SCREEN, ST_GMAP, ST_START, ST_EXT, ST_SKIP, ST_BLKLEN, ST_CTRL,
        ST_APP, ST_LOOPLEN, ST_LOOPDATA, ST_IMGHDR, ST_LMAP, ST_LZWSTART, ST_SUBLEN,
        ST_LZW, ST_DONE, ST_ERROR, ST_HALT
    } parse_state_t;

    typedef enum logic [3:0] {
        EV_LZW_SIZE  = 4'd0,
        EV_LZW_BYTE  = 4'd1,
        EV_FRAME     = 4'd2,
        EV_IMAGE     = 4'd3,
        EV_CONTROL   = 4'd4,
        EV_LOOP      = 4'd5,
        EV_MAP       = 4'd6,
        EV_DONE      = 4'd7,
        EV_ERROR     = 4'd8,
        EV_SIZE_ONLY = 4'd9
    } event_t;

    typedef struct packed {
        event_t      ev;
        logic [7:0]  byte_value;
        logic [15:0] x_offset;
        logic [15:0] y_offset;
        logic [15:0] frame_width;
        logic [15:0] frame_height;
        logic [15:0] screen_width;
        logic [15:0] screen_height;
        logic [3:0]  frame_flags;
        logic [1:0]  disposal;
        logic [19:0] delay_or_loop;
    } result_t;

    localparam int MAP_ENTRY_BYTES = 3;
    localparam int APP_ID_BYTES    = 11;
    localparam logic [7:0] EXT_INTRO   = 8'h21;
    localparam logic [7:0] IMG_INTRO   = 8'h2c;
    localparam logic [7:0] LBL_CONTROL = 8'hf9;
    localparam logic [7:0] LBL_APP     = 8'hff;

    localparam logic [47:0] SIG_89 = {"a", "9", "8", "F", "I", "G"};
    localparam logic [47:0] SIG_87 = {"a", "7", "8", "F", "I", "G"};
    localparam logic [87:0] APP_A  =
        {"0", ".", "2", "E", "P", "A", "C", "S", "T", "E", "N"};
    localparam logic [87:0] APP_B  =
        {"0", ".", "1", "S", "T", "X", "E", "M", "I", "N", "A"};

    // Saturating growth of a screen dimension by a frame edge
    function automatic logic [15:0] grow(input logic [15:0] cur, input logic [15:0] off,
                                         input logic [15:0] size);
        logic [16:0] s;
        logic [15:0] t;
        begin
            s = {1'b0, off} + {1'b0, size};
            t = s[16] ? 16'hffff : s[15:0];
            grow = (t > cur) ? t : cur;
        end
    endfunction

    // Colour map length in bytes from a 3-bit size field
    function automatic logic [9:0] map_len(input logic [2:0] sz);
        logic [9:0] n;
        begin
            n = 10'd2 << sz;
            map_len = (n << 1) + n;
        end
    endfunction

endpackage

>>> rtl/core/gifp_out_reg.sv
// Result register with a skid stage so that input acceptance stalls only when two words wait.
`timescale 1ns / 1ps
module gifp_out_reg
    import gifp_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    output logic    in_ready,
    input  result_t in_word,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_word
);

    logic    main_valid_reg, skid_valid_reg;
    result_t main_reg, skid_reg;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_word  = main_reg;

    // main holds the word on show, skid catches one word while main stalls
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (!main_valid_reg || out_ready) begin
                if (skid_valid_reg) begin
                    main_reg       <= skid_reg;
                    main_valid_reg <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end else begin
                    main_reg       <= in_word;
                    main_valid_reg <= in_valid;
                end
            end else if (in_valid && in_ready) begin
                skid_reg       <= in_word;
                skid_valid_reg <= 1'b1;
            end
        end
    end

endmodule

>>> rtl/core/gifp_parser.sv
// Byte-level parse state machine: one byte updates state and yields at most one word.
`timescale 1ns / 1ps
module gifp_parser
    import gifp_pkg::*;
#(
    parameter int MAX_FIELD_BYTES = 11
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       byte_valid,
    input  logic [7:0] data_byte,
    input  logic       stop_after_size,
    output logic       res_valid,
    output result_t    res_word
);

    localparam int IW = $clog2(MAX_FIELD_BYTES + 1);

    parse_state_t st_reg, st_next;
    logic [9:0]   left_reg, left_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic [7:0]   fb_reg [MAX_FIELD_BYTES];
    logic [15:0]  sw_reg, sw_next, sh_reg, sh_next;
    logic [1:0]   fs_reg, fs_next;
    logic         open_reg, open_next, loc_reg, loc_next;
    logic         last, store;
    logic [7:0]   f [MAX_FIELD_BYTES];
    logic         first_now, first_after;
    logic [15:0]  gw, gh, fw, fh;
    logic [2:0]   raw;
    logic [9:0]   ext_n;
    logic [47:0]  sig;
    logic [87:0]  app;

    assign last  = left_reg <= 10'd1;
    assign store = idx_reg < IW'(MAX_FIELD_BYTES);

    // field bytes as they stand after this byte is stored
    always_comb begin
        for (int i = 0; i < MAX_FIELD_BYTES; i++)
            f[i] = (store && idx_reg == IW'(i)) ? data_byte : fb_reg[i];
        for (int i = 0; i < 6; i++) sig[i*8 +: 8] = f[i];
        for (int i = 0; i < APP_ID_BYTES; i++) app[i*8 +: 8] = f[i];
    end

    always_comb begin
        st_next = st_reg; left_next = left_reg; idx_next = idx_reg;
        sw_next = sw_reg; sh_next = sh_reg; fs_next = fs_reg;
        open_next = open_reg; loc_next = loc_reg;
        res_valid = 1'b0; res_word = '0;
        first_now = (fs_reg == 2'd0) || (fs_reg == 2'd1 && open_reg);
        // a frame opened now is the first only if none was started before
        first_after = (fs_reg == 2'd0);
        gw = grow(sw_reg, {f[1], f[0]}, {f[5], f[4]});
        gh = grow(sh_reg, {f[3], f[2]}, {f[7], f[6]});
        raw = f[0][4:2];
        ext_n = {2'b0, f[1]};
        fw = {f[5], f[4]}; fh = {f[7], f[6]};
        if (byte_valid) begin
            unique case (st_reg)
                ST_DONE, ST_ERROR, ST_HALT: ;
                ST_GMAP, ST_LMAP, ST_LZW: begin
                    res_valid = 1'b1;
                    res_word.ev = (st_reg == ST_LZW) ? EV_LZW_BYTE : EV_MAP;
                    res_word.byte_value = data_byte;
                    if (st_reg != ST_LZW) res_word.frame_flags = {2'b0, loc_reg, 1'b0};
                    if (!last) left_next = left_reg - 10'd1;
                    else begin
                        left_next = 10'd1; idx_next = '0;
                        st_next = (st_reg == ST_GMAP) ? ST_START :
                                  (st_reg == ST_LMAP) ? ST_LZWSTART : ST_SUBLEN;
                    end
                end
                default: begin
                    if (store) idx_next = idx_reg + IW'(1);
                    if (!last) left_next = left_reg - 10'd1;
                    else begin
                        left_next = 10'd1; idx_next = '0;
                        unique case (st_reg)
                            ST_SIG: begin
                                if (sig != SIG_89 && sig != SIG_87) begin
                                    res_valid = 1'b1; res_word.ev = EV_ERROR;
                                    st_next = ST_ERROR;
                                end else begin
                                    left_next = 10'd7; st_next = ST_SCREEN;
                                end
                            end
                            ST_SCREEN: begin
                                sw_next = {f[1], f[0]}; sh_next = {f[3], f[2]};
                                if (f[4][7]) begin
                                    loc_next = 1'b0; left_next = map_len(f[4][2:0]);
                                    st_next = ST_GMAP;
                                end else st_next = ST_START;
                            end
                            ST_START: begin
                                if (data_byte == EXT_INTRO) begin
                                    left_next = 10'd2; st_next = ST_EXT;
                                end else if (data_byte == IMG_INTRO) begin
                                    left_next = 10'd9; st_next = ST_IMGHDR;
                                end else begin
                                    res_valid = 1'b1; res_word.ev = EV_DONE;
                                    st_next = ST_DONE;
                                end
                            end
                            ST_EXT: begin
                                if (f[0] == LBL_CONTROL) begin
                                    left_next = (ext_n < 10'd4) ? 10'd4 : ext_n;
                                    st_next = ST_CTRL;
                                end else if (ext_n == 10'd0) st_next = ST_START;
                                else begin
                                    left_next = ext_n;
                                    st_next = (f[0] == LBL_APP && ext_n == 10'(APP_ID_BYTES))
                                              ? ST_APP : ST_SKIP;
                                end
                            end
                            ST_SKIP: st_next = ST_BLKLEN;
                            ST_BLKLEN: begin
                                if (data_byte != 8'd0) begin
                                    left_next = {2'b0, data_byte}; st_next = ST_SKIP;
                                end else st_next = ST_START;
                            end
                            ST_CTRL: begin
                                if (!open_reg) begin
                                    open_next = 1'b1;
                                    if (fs_reg != 2'd3) fs_next = fs_reg + 2'd1;
                                end
                                res_valid = 1'b1; res_word.ev = EV_CONTROL;
                                if (f[0][0]) begin
                                    res_word.byte_value = f[3];
                                    res_word.frame_flags[2] = 1'b1;
                                end
                                res_word.frame_flags[3] = open_reg ? first_now : first_after;
                                res_word.disposal = (raw < 3'd4) ? raw[1:0] :
                                                    (raw == 3'd4) ? 2'd3 : 2'd0;
                                res_word.delay_or_loop = ({4'b0, f[2], f[1]} << 3) +
                                                         ({4'b0, f[2], f[1]} << 1);
                                st_next = ST_BLKLEN;
                            end
                            ST_APP: st_next = (app == APP_A || app == APP_B)
                                              ? ST_LOOPLEN : ST_BLKLEN;
                            ST_LOOPLEN: begin
                                if (data_byte != 8'd0) begin
                                    left_next = (data_byte < 8'd3) ? 10'd3 : {2'b0, data_byte};
                                    st_next = ST_LOOPDATA;
                                end else st_next = ST_START;
                            end
                            ST_LOOPDATA: begin
                                if (f[0][2:0] == 3'd1) begin
                                    res_valid = 1'b1; res_word.ev = EV_LOOP;
                                    res_word.delay_or_loop = {4'b0, f[2], f[1]};
                                    st_next = ST_LOOPLEN;
                                end else if (f[0][2:0] == 3'd2) st_next = ST_LOOPLEN;
                                else begin
                                    res_valid = 1'b1; res_word.ev = EV_ERROR;
                                    st_next = ST_ERROR;
                                end
                            end
                            ST_IMGHDR: begin
                                if (first_now) begin
                                    sw_next = gw; sh_next = gh;
                                end
                                res_valid = 1'b1;
                                if (stop_after_size) begin
                                    res_word.ev = EV_SIZE_ONLY;
                                    res_word.screen_width = sw_next;
                                    res_word.screen_height = sh_next;
                                    st_next = ST_HALT;
                                end else begin
                                    if (!open_reg) begin
                                        open_next = 1'b1;
                                        if (fs_reg != 2'd3) fs_next = fs_reg + 2'd1;
                                    end
                                    if (fw == 16'd0 || fh == 16'd0) begin
                                        fw = sw_next; fh = sh_next;
                                    end
                                    if (fw == 16'd0 || fh == 16'd0) begin
                                        res_word.ev = EV_ERROR; st_next = ST_ERROR;
                                    end else begin
                                        res_word.ev = EV_IMAGE;
                                        res_word.x_offset = {f[1], f[0]};
                                        res_word.y_offset = {f[3], f[2]};
                                        res_word.frame_width = fw;
                                        res_word.frame_height = fh;
                                        res_word.screen_width = sw_next;
                                        res_word.screen_height = sh_next;
                                        res_word.frame_flags = {open_reg ? first_now :
                                            first_after, 1'b0, f[8][7], f[8][6]};
                                        if (f[8][7]) begin
                                            loc_next = 1'b1;
                                            left_next = map_len(f[8][2:0]);
                                            st_next = ST_LMAP;
                                        end else st_next = ST_LZWSTART;
                                    end
                                end
                            end
                            ST_LZWSTART: begin
                                res_valid = 1'b1; res_word.ev = EV_LZW_SIZE;
                                res_word.byte_value = data_byte;
                                st_next = ST_SUBLEN;
                            end
                            ST_SUBLEN: begin
                                if (data_byte != 8'd0) begin
                                    left_next = {2'b0, data_byte}; st_next = ST_LZW;
                                end else begin
                                    open_next = 1'b0;
                                    res_valid = 1'b1; res_word.ev = EV_FRAME;
                                    st_next = ST_START;
                                end
                            end
                            default: begin
                                res_valid = 1'b1; res_word.ev = EV_ERROR;
                                st_next = ST_ERROR;
                            end
                        endcase
                    end
                end
            endcase
        end
    end

    // parse state and field buffer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= ST_SIG; left_reg <= 10'd6; idx_reg <= '0;
            sw_reg <= '0; sh_reg <= '0; fs_reg <= '0; open_reg <= 1'b0; loc_reg <= 1'b0;
        end else begin
            st_reg <= st_next; left_reg <= left_next; idx_reg <= idx_next;
            sw_reg <= sw_next; sh_reg <= sh_next; fs_reg <= fs_next;
            open_reg <= open_next; loc_reg <= loc_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (byte_valid && store && st_reg != ST_GMAP && st_reg != ST_LMAP &&
            st_reg != ST_LZW)
            fb_reg[idx_reg[$clog2(MAX_FIELD_BYTES)-1:0]] <= data_byte;
    end

endmodule

>>> rtl/core/gif_container_block_parser.sv
// Top level of the GIF container block parser.
// A result word is registered in the output stage (main register, or skid register while m_ stalls).
// Throughput: one byte per cycle while s_ready is high; each accepted byte updates the parse state.
// s_ready drops only while the skid stage is full behind a stalled m_ side.
// Reset (aresetn low, synchronous) returns the parser to signature checking
// and clears stop_after_size; the field buffer is not cleared.
`timescale 1ns / 1ps
module gif_container_block_parser
    import gifp_pkg::*;
#(
    parameter int MAX_FIELD_BYTES = 11
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_event_res,
    output logic [7:0]  m_byte_value,
    output logic [15:0] m_x_offset,
    output logic [15:0] m_y_offset,
    output logic [15:0] m_frame_width,
    output logic [15:0] m_frame_height,
    output logic [15:0] m_screen_width,
    output logic [15:0] m_screen_height,
    output logic [3:0]  m_frame_flags,
    output logic [1:0]  m_disposal,
    output logic [19:0] m_delay_or_loop
);

    logic    stop_reg;
    logic    res_valid;
    result_t res_word, out_word;

    assign cfg_ready = 1'b1;

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) stop_reg <= 1'b0;
        else if (cfg_valid) stop_reg <= cfg_data;
    end

    gifp_parser #(.MAX_FIELD_BYTES(MAX_FIELD_BYTES)) u_parser (
        .aclk(aclk), .aresetn(aresetn), .byte_valid(s_valid && s_ready),
        .data_byte(s_data_byte), .stop_after_size(stop_reg),
        .res_valid(res_valid), .res_word(res_word)
    );

    gifp_out_reg u_out (
        .aclk(aclk), .aresetn(aresetn), .in_valid(res_valid), .in_ready(s_ready),
        .in_word(res_word), .out_valid(m_valid), .out_ready(m_ready), .out_word(out_word)
    );

    assign m_event_res     = out_word.ev;
    assign m_byte_value    = out_word.byte_value;
    assign m_x_offset      = out_word.x_offset;
    assign m_y_offset      = out_word.y_offset;
    assign m_frame_width   = out_word.frame_width;
    assign m_frame_height  = out_word.frame_height;
    assign m_screen_width  = out_word.screen_width;
    assign m_screen_height = out_word.screen_height;
    assign m_frame_flags   = out_word.frame_flags;
    assign m_disposal      = out_word.disposal;
    assign m_delay_or_loop = out_word.delay_or_loop;

    // a result word never carries an event code outside the defined set
    a_event_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_event_res <= EV_SIZE_ONLY)
        else $error("undefined event code");

    // a stalled output word stays valid with its event code held
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_event_res))
        else $error("output word changed while stalled");

    // input is refused only while a result waits
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("input stalled with no pending output");

endmodule
